@@ hw/rtl/asc8fr_pkg.sv @@
package asc8fr_pkg;

  localparam int BYTE_W = 8;
  localparam logic [BYTE_W-1:0] CRC_POLY = 8'h07;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

  function automatic byte_t crc_feed(input byte_t crc, input byte_t din);
    byte_t c;
    c = crc ^ din;
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[BYTE_W-1]) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

@@ hw/rtl/asc8fr_cell.sv @@
module asc8fr_cell (
  input  logic                clk,
  input  asc8fr_pkg::cell_ctrl_t ctrl,
  input  asc8fr_pkg::byte_t   shift_in,
  input  asc8fr_pkg::byte_t   load_in,
  output asc8fr_pkg::byte_t   q
);

  asc8fr_pkg::byte_t q_r;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      q_r <= load_in;
    end else if (ctrl.shift) begin
      q_r <= shift_in;
    end
  end

  assign q = q_r;

endmodule

@@ hw/rtl/address_sync_crc8_frame_receiver.sv @@
// Fixed-length frame receiver. While idle, bytes are dropped until one equals
// the device address; that byte and the following FRAME_LEN-1 bytes form a
// frame. A CRC-8 (poly 0x07, init 0) over all but the last byte must equal the
// last byte; a good frame is then sent out as FRAME_LEN bytes, one per cycle
// while out_tready is high, with byte_index on every byte and tlast on the
// final byte. Bad frames are dropped silently. A final byte equal to the
// address opens the next frame. Input bytes are taken one per cycle; the only
// stall is on the final byte of a frame while the previous good frame is
// still being sent from the output cell chain.
module address_sync_crc8_frame_receiver #(
  parameter int FRAME_LEN = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,     // device_address
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,      // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,     // [7:0] frame_byte, [13:8] byte_index, [15:14] zero
  output logic        out_tlast      // last_of_frame
);

  localparam int IDX_W = $clog2(FRAME_LEN);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);

  asc8fr_pkg::byte_t addr_r;
  asc8fr_pkg::byte_t crc_r, crc_nxt;
  logic [IDX_W-1:0]  fill_r, fill_nxt;
  logic [IDX_W-1:0]  oidx_r, oidx_nxt;
  logic              busy_r, busy_nxt;

  asc8fr_pkg::byte_t cap_q   [FRAME_LEN];
  asc8fr_pkg::byte_t cap_in  [FRAME_LEN];
  asc8fr_pkg::byte_t emit_q  [FRAME_LEN];
  asc8fr_pkg::byte_t emit_in [FRAME_LEN];

  asc8fr_pkg::cell_ctrl_t cap_ctrl, emit_ctrl;

  logic in_fire, out_fire, take, last_byte, good;
  asc8fr_pkg::byte_t b;

  assign b         = in_tdata;
  assign in_tready = !(busy_r && fill_r == LAST_IDX);
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_tvalid && out_tready;
  assign take      = in_fire && (fill_r != '0 || b == addr_r);
  assign last_byte = fill_r == LAST_IDX;
  assign good      = take && last_byte && crc_r == b;

  always_comb begin
    crc_nxt  = crc_r;
    fill_nxt = fill_r;
    if (take) begin
      if (last_byte) begin
        if (b == addr_r) begin
          fill_nxt = IDX_W'(1);
          crc_nxt  = asc8fr_pkg::crc_feed('0, b);
        end else begin
          fill_nxt = '0;
          crc_nxt  = '0;
        end
      end else begin
        fill_nxt = fill_r + IDX_W'(1);
        crc_nxt  = asc8fr_pkg::crc_feed(crc_r, b);
      end
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    oidx_nxt = oidx_r;
    if (good) begin
      busy_nxt = 1'b1;
      oidx_nxt = '0;
    end else if (out_fire) begin
      if (oidx_r == LAST_IDX) begin
        busy_nxt = 1'b0;
      end else begin
        oidx_nxt = oidx_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= '0;
      crc_r  <= '0;
      fill_r <= '0;
      oidx_r <= '0;
      busy_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        addr_r <= cfg_wdata;
      end
      crc_r  <= crc_nxt;
      fill_r <= fill_nxt;
      oidx_r <= oidx_nxt;
      busy_r <= busy_nxt;
    end
  end

  always_comb begin
    cap_ctrl.load   = 1'b0;
    cap_ctrl.shift  = take;
    emit_ctrl.load  = good;
    emit_ctrl.shift = out_fire;
  end

  for (genvar i = 0; i < FRAME_LEN; i++) begin : g_cells
    if (i == FRAME_LEN - 1) begin : g_tail
      assign cap_in[i]  = b;
      assign emit_in[i] = '0;
    end else begin : g_body
      assign cap_in[i]  = cap_q[i+1];
      assign emit_in[i] = emit_q[i+1];
    end

    asc8fr_cell u_cap (
      .clk      (clk),
      .ctrl     (cap_ctrl),
      .shift_in (cap_in[i]),
      .load_in  (cap_in[i]),
      .q        (cap_q[i])
    );

    asc8fr_cell u_emit (
      .clk      (clk),
      .ctrl     (emit_ctrl),
      .shift_in (emit_in[i]),
      .load_in  (cap_in[i]),
      .q        (emit_q[i])
    );
  end

  assign out_tvalid = busy_r;
  assign out_tdata  = {2'b00, 6'(oidx_r), emit_q[0]};
  assign out_tlast  = oidx_r == LAST_IDX;

endmodule
